@@ rtl/hpd_pkg.sv @@
`default_nettype none

package hpd_pkg;

  // Widths of the received byte and of the result fields.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AttnW    = 4;
  localparam int unsigned TtlW     = 2;
  localparam int unsigned LengthW  = 3;
  localparam int unsigned IdW      = 5;
  localparam int unsigned PayBytes = 7;
  localparam int unsigned PayloadW = PayBytes * ByteW;

  // Header field positions within the 16-bit header.
  localparam int unsigned AttnLsb   = 12;
  localparam int unsigned TtlLsb    = 8;
  localparam int unsigned LengthLsb = 5;
  localparam int unsigned IdLsb     = 0;

  // One assembled packet as it leaves the block.
  typedef struct packed {
    logic [AttnW-1:0]    attn_code;
    logic [TtlW-1:0]     time_to_live;
    logic [LengthW-1:0]  payload_length;
    logic [IdW-1:0]      packet_id;
    logic [PayloadW-1:0] payload;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/hpd_assembler.sv @@
`default_nettype none

module hpd_assembler (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [hpd_pkg::ByteW-1:0] byte_i,
  output logic                           done_o,
  output hpd_pkg::result_t               result_o
);
  import hpd_pkg::*;

  typedef enum logic [1:0] {
    PhHigh = 2'd0,
    PhLow  = 2'd1,
    PhData = 2'd2
  } phase_e;

  typedef logic [PayBytes-1:0][ByteW-1:0] pay_t;

  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    high_q, high_d;
  logic [LengthW-1:0]  rem_q, rem_d;
  logic [AttnW-1:0]    attn_q, attn_d;
  logic [TtlW-1:0]     ttl_q, ttl_d;
  logic [LengthW-1:0]  len_q, len_d;
  logic [IdW-1:0]      id_q, id_d;
  pay_t                pay_q, pay_d;
  logic [2*ByteW-1:0]  header;
  logic                done;

  assign header = {high_q, byte_i};

  // Next state of the deframer for the byte in the input register.
  always_comb begin
    phase_d = phase_q;
    high_d  = high_q;
    rem_d   = rem_q;
    attn_d  = attn_q;
    ttl_d   = ttl_q;
    len_d   = len_q;
    id_d    = id_q;
    pay_d   = pay_q;
    done    = 1'b0;
    unique case (phase_q)
      PhLow: begin
        attn_d = header[AttnLsb +: AttnW];
        ttl_d  = header[TtlLsb +: TtlW];
        len_d  = header[LengthLsb +: LengthW];
        id_d   = header[IdLsb +: IdW];
        rem_d  = header[LengthLsb +: LengthW];
        pay_d  = '0;
        if (header[LengthLsb +: LengthW] == '0) begin
          // A packet without payload completes on its second header byte.
          phase_d = PhHigh;
          done    = 1'b1;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        // The first payload byte lands at index payload_length-1, the last at index 0.
        rem_d = rem_q - LengthW'(1);
        for (int i = 0; i < PayBytes; i++) begin
          if (rem_d == LengthW'(i)) begin
            pay_d[i] = pay_q[i] | byte_i;
          end
        end
        if (rem_d == '0) begin
          phase_d = PhHigh;
          done    = 1'b1;
        end
      end
      default: begin
        // Header high byte; the unused phase code behaves the same way.
        high_d  = byte_i;
        phase_d = PhLow;
      end
    endcase
  end

  // State registers, updated once per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHigh;
      high_q  <= '0;
      rem_q   <= '0;
      attn_q  <= '0;
      ttl_q   <= '0;
      len_q   <= '0;
      id_q    <= '0;
      pay_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      high_q  <= high_d;
      rem_q   <= rem_d;
      attn_q  <= attn_d;
      ttl_q   <= ttl_d;
      len_q   <= len_d;
      id_q    <= id_d;
      pay_q   <= pay_d;
    end
  end

  assign done_o                  = step_i & done;
  assign result_o.attn_code      = attn_d;
  assign result_o.time_to_live   = ttl_d;
  assign result_o.payload_length = len_d;
  assign result_o.packet_id      = id_d;
  assign result_o.payload        = pay_d;

endmodule

`default_nettype wire

@@ rtl/header_packet_deframer.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// rx        in         rx_valid_i/rx_stall_o  rx_byte_i
// res       out        res_valid_o/res_stall_i attn_code_o, time_to_live_o,
//                                             payload_length_o, packet_id_o, payload_o
//
// One byte is taken per cycle while rx_stall_o is low. A byte is held in the input
// register, and the packet it completes is then registered in the output register.
// Reset clears the deframer to wait for a header high byte and empties both
// registers. A stalled result holds the pipeline; the input register keeps
// accepting while the result register is free or being emptied.

module header_packet_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rx_valid_i,
  output logic                              rx_stall_o,
  input  wire logic [hpd_pkg::ByteW-1:0]    rx_byte_i,
  output logic                              res_valid_o,
  input  wire logic                         res_stall_i,
  output logic [hpd_pkg::AttnW-1:0]         attn_code_o,
  output logic [hpd_pkg::TtlW-1:0]          time_to_live_o,
  output logic [hpd_pkg::LengthW-1:0]       payload_length_o,
  output logic [hpd_pkg::IdW-1:0]           packet_id_o,
  output logic [hpd_pkg::PayloadW-1:0]      payload_o
);
  import hpd_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             advance;
  logic             step;
  logic             done;
  result_t          result;

  // The pipeline moves whenever the result register can take a transaction.
  assign advance    = !out_valid_q || !res_stall_i;
  assign step       = in_valid_q && advance;
  assign rx_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!rx_stall_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && !rx_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  hpd_assembler u_assembler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .done_o   (done),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign attn_code_o      = out_q.attn_code;
  assign time_to_live_o   = out_q.time_to_live;
  assign payload_length_o = out_q.payload_length;
  assign packet_id_o      = out_q.packet_id;
  assign payload_o        = out_q.payload;

endmodule

`default_nettype wire
